// ===== rtl/rtd_pkg.sv =====
// Package for the reversible trace digest: operation codes, payload and command types,
// seed lanes, multiplier constants and the lane arithmetic helpers.
// No dependencies.
package rtd_pkg;

  localparam int unsigned LANE_COUNT = 8;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_FORWARD = 2'd1,
    OP_INVERSE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] symbol;
  } in_data_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic [31:0] digest_word5;
    logic [31:0] digest_word6;
    logic [31:0] digest_word7;
  } out_data_t;

  typedef struct packed {
    logic load;
    logic mix;
    logic commit;
  } cmd_t;

  localparam logic [31:0] MIX_MUL_A    = 32'h7feb352d;
  localparam logic [31:0] MIX_MUL_B    = 32'h846ca68b;
  localparam logic [31:0] KEY_OFFSET   = 32'(64'h9e3779b9 * 64'd3);
  localparam logic [31:0] LANE_MUL     = 32'h9e3779b1;
  localparam logic [31:0] LANE_MUL_INV = 32'h0e8b2f51;
  localparam logic [31:0] SEED_ADJUST  = 32'(64'h00010001 * 64'd3);

  localparam logic [31:0] SEED_LANES [LANE_COUNT] = '{
    32'h243f6a88 ^ SEED_ADJUST, 32'h85a308d3, 32'h13198a2e, 32'h03707344,
    32'ha4093822, 32'h299f31d0, 32'h082efa98, 32'hec4e6c89
  };

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} << s;
    return d[63:32];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] d;
    d = {v, v} >> s;
    return d[31:0];
  endfunction

endpackage

// ===== rtl/rtd_ctrl.sv =====
// Controller for the reversible trace digest: sequences accept, key mix and lane update.
// Depends on rtd_pkg for the command type.
module rtd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output rtd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_LANE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free  = !out_valid_r || !out_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;

  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.mix    = (state_r == S_MIX);
  assign cmd.commit = (state_r == S_LANE) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        state_nxt = S_LANE;
      end
      S_LANE: begin
        if (slot_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/rtd_datapath.sv =====
// Datapath for the reversible trace digest: lane registers, key mixer, lane multipliers
// and the output register. Depends on rtd_pkg; driven by rtd_ctrl commands.
module rtd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rtd_pkg::cmd_t     cmd,
  input  rtd_pkg::in_data_t in_data,
  output rtd_pkg::out_data_t out_data
);

  rtd_pkg::op_t       op_r;
  logic [31:0]        sym_r;
  logic [31:0]        m1_r;
  logic [31:0]        k_r;
  logic [31:0]        prod_r  [rtd_pkg::LANE_COUNT];
  logic [31:0]        lanes_r [rtd_pkg::LANE_COUNT];
  logic [31:0]        lanes_nxt [rtd_pkg::LANE_COUNT];
  logic [31:0]        pre     [rtd_pkg::LANE_COUNT];
  logic [31:0]        fwd     [rtd_pkg::LANE_COUNT];
  logic [4:0]         shamt   [rtd_pkg::LANE_COUNT];
  rtd_pkg::out_data_t out_data_r;
  logic [31:0]        x0, v1, v2, v3;

  assign x0 = in_data.symbol + rtd_pkg::KEY_OFFSET;
  assign v1 = x0 ^ (x0 >> 16);
  assign v2 = m1_r ^ (m1_r >> 15);
  assign v3 = rtd_pkg::mul32(v2, rtd_pkg::MIX_MUL_B);

  always_comb begin
    for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
      pre[i] = lanes_r[i];
    end
    pre[0] = lanes_r[6];
    pre[3] = lanes_r[0];
    pre[6] = lanes_r[3];
  end

  always_comb begin
    for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
      shamt[i] = sym_r[4:0] + 5'(i * 7);
      fwd[i]   = rtd_pkg::mul32(rtd_pkg::rol32(lanes_r[i] ^ k_r, shamt[i]), rtd_pkg::LANE_MUL);
    end
    case (op_r)
      rtd_pkg::OP_RESTART: begin
        for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
          lanes_nxt[i] = rtd_pkg::SEED_LANES[i];
        end
      end
      rtd_pkg::OP_FORWARD: begin
        for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
          lanes_nxt[i] = fwd[i];
        end
        lanes_nxt[0] = fwd[3];
        lanes_nxt[3] = fwd[6];
        lanes_nxt[6] = fwd[0];
      end
      rtd_pkg::OP_INVERSE: begin
        for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
          lanes_nxt[i] = rtd_pkg::ror32(prod_r[i], shamt[i]) ^ k_r;
        end
      end
      default: begin
        for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
          lanes_nxt[i] = lanes_r[i];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      sym_r <= in_data.symbol;
      m1_r  <= rtd_pkg::mul32(v1, rtd_pkg::MIX_MUL_A);
      for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
        prod_r[i] <= rtd_pkg::mul32(pre[i], rtd_pkg::LANE_MUL_INV);
      end
    end
    if (cmd.mix) begin
      k_r <= v3 ^ (v3 >> 16);
    end
    if (cmd.commit) begin
      out_data_r.digest_word0 <= lanes_nxt[0];
      out_data_r.digest_word1 <= lanes_nxt[1];
      out_data_r.digest_word2 <= lanes_nxt[2];
      out_data_r.digest_word3 <= lanes_nxt[3];
      out_data_r.digest_word4 <= lanes_nxt[4];
      out_data_r.digest_word5 <= lanes_nxt[5];
      out_data_r.digest_word6 <= lanes_nxt[6];
      out_data_r.digest_word7 <= lanes_nxt[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
        lanes_r[i] <= rtd_pkg::SEED_LANES[i];
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < rtd_pkg::LANE_COUNT; i++) begin
        lanes_r[i] <= lanes_nxt[i];
      end
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== rtl/reversible_trace_digest.sv =====
// Reversible trace digest: eight 32-bit lanes absorb (forward) or remove (inverse) one
// 32-bit symbol per transaction, or restart from the seed lanes, and every transaction
// returns all eight lanes. The accept step runs the first key mixer multiply and the
// inverse lane products, the mix step the second mixer multiply, and the lane step the
// lane update, which loads the output register. The next item is taken the cycle after
// the lane update; no new item is taken until then. A stalled result that is still held
// when the lane update is due delays it until the output register frees. Op code 3 leaves
// the lanes unchanged and still returns them. Depends on rtd_pkg, rtd_ctrl, rtd_datapath.
module reversible_trace_digest (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtd_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rtd_pkg::out_data_t out_data
);

  rtd_pkg::cmd_t cmd;

  rtd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rtd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
